// ===== design/lyt_pkg.sv =====
// Shared constants, types and tables for the LiDAR yaw time reconstructor.
package lyt_pkg;

    localparam int MAX_RINGS    = 128;
    localparam int RING_W       = $clog2(MAX_RINGS);
    localparam int CORDIC_ITERS = 16;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);

    localparam logic [1:0] CFG_BLIND    = 2'd0;
    localparam logic [1:0] CFG_DECIM    = 2'd1;
    localparam logic [1:0] CFG_RINGS    = 2'd2;
    localparam logic [1:0] CFG_RING_EN  = 2'd3;

    localparam logic [17:0]        TIME_MAX   = 18'd200000;
    localparam logic [17:0]        REV_US     = 18'd99723;
    localparam logic [16:0]        FULL_TURN  = 17'd92160;
    localparam logic signed [26:0] YAW_LIMIT  = 27'sd46080;
    localparam logic signed [26:0] HALF_TURN  = 27'sd11796480;
    // 92416 = 361 << 8; ceil(2^35 / 361) for the divide by 361
    localparam logic [26:0]        DIV_RECIP  = 27'd95179331;
    localparam logic [16:0]        TIME_MUL   = 17'd100000;
    localparam logic [33:0]        TIME_BIAS  = 34'd46208;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_CHECK,
        S_CORDIC,
        S_MULT,
        S_DSTART,
        S_DIV,
        S_OUT
    } t_state;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [26:0] atan_val(input logic [4:0] idx);
        logic signed [26:0] v;
        begin
            unique case (idx)
                5'd0:  v = 27'sd2949120;
                5'd1:  v = 27'sd1740967;
                5'd2:  v = 27'sd919879;
                5'd3:  v = 27'sd466945;
                5'd4:  v = 27'sd234379;
                5'd5:  v = 27'sd117304;
                5'd6:  v = 27'sd58666;
                5'd7:  v = 27'sd29335;
                5'd8:  v = 27'sd14668;
                5'd9:  v = 27'sd7334;
                5'd10: v = 27'sd3667;
                5'd11: v = 27'sd1833;
                5'd12: v = 27'sd917;
                5'd13: v = 27'sd458;
                5'd14: v = 27'sd229;
                5'd15: v = 27'sd115;
                5'd16: v = 27'sd57;
                5'd17: v = 27'sd29;
                5'd18: v = 27'sd14;
                5'd19: v = 27'sd7;
                5'd20: v = 27'sd4;
                5'd21: v = 27'sd2;
                5'd22: v = 27'sd1;
                default: v = 27'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== design/lyt_in_if.sv =====
// Point input channel.
interface lyt_in_if;
    logic               valid;
    logic               ready;
    logic               scan_start;
    logic               coord_ok;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [15:0]        strength;
    logic [7:0]         ring_id;

    modport source (output valid, scan_start, coord_ok, pos_x, pos_y, pos_z,
                    strength, ring_id, input ready);
    modport sink   (input valid, scan_start, coord_ok, pos_x, pos_y, pos_z,
                    strength, ring_id, output ready);
endinterface

// ===== design/lyt_out_if.sv =====
// Timed point output channel.
interface lyt_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [15:0]        out_strength;
    logic [6:0]         out_ring;
    logic [17:0]        time_us;

    modport source (output valid, out_x, out_y, out_z, out_strength, out_ring,
                    time_us, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_strength, out_ring,
                    time_us, output ready);
endinterface

// ===== design/lyt_cordic.sv =====
// Iterative vectoring CORDIC, one rotation per cycle, yaw in 1/256 degree.
module lyt_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [23:0] i_x,
    input  logic signed [23:0] i_y,
    output logic               o_done,
    output logic signed [16:0] o_yaw
);

    localparam int ITER_W = lyt_pkg::ITER_W;

    logic                            r_busy, r_fin, r_done;
    logic signed [35:0]              r_x, r_y;
    logic signed [26:0]              r_z;
    logic [lyt_pkg::ITER_W-1:0]      r_i;
    logic signed [16:0]              r_yaw;

    logic signed [24:0] x0, y0;
    logic signed [35:0] dx, dy;
    logic signed [26:0] ang, zr;

    assign x0  = 25'(i_x);
    assign y0  = 25'(i_y);
    assign dx  = r_y >>> r_i;
    assign dy  = r_x >>> r_i;
    assign ang = lyt_pkg::atan_val(5'(r_i));
    // round half up to 1/256 deg
    assign zr  = (r_z + 27'sd128) >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (i_x == 24'sd0 && i_y == 24'sd0) begin
                    r_z    <= '0;
                    r_fin  <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    if (i_x < 0) begin
                        r_z <= (i_y >= 0) ? lyt_pkg::HALF_TURN : -lyt_pkg::HALF_TURN;
                        r_x <= 36'(-x0) <<< 8;
                        r_y <= 36'(-y0) <<< 8;
                    end else begin
                        r_z <= '0;
                        r_x <= 36'(x0) <<< 8;
                        r_y <= 36'(y0) <<< 8;
                    end
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + ang;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - ang;
                end
                r_i <= r_i + 1'b1;
                if (r_i == ITER_W'(lyt_pkg::CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                if (zr > lyt_pkg::YAW_LIMIT)
                    r_yaw <= 17'(lyt_pkg::YAW_LIMIT);
                else if (zr < -lyt_pkg::YAW_LIMIT)
                    r_yaw <= 17'(-lyt_pkg::YAW_LIMIT);
                else
                    r_yaw <= 17'(zr);
            end
        end
    end

    assign o_done = r_done;
    assign o_yaw  = r_yaw;

endmodule

// ===== design/lyt_div.sv =====
// Divide by the fixed time scale: shift by 8, then reciprocal multiply by 1/361.
module lyt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [33:0] i_num,
    output logic        o_done,
    output logic [16:0] o_quo
);

    logic        r_busy, r_done;
    logic [25:0] r_m;
    logic [16:0] r_q;
    logic [52:0] prod;

    // exact for every 26-bit r_m: reciprocal error 123 is below 2^(35-26)
    assign prod = 53'(r_m) * 53'(lyt_pkg::DIV_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_m    <= i_num[33:8];
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_q    <= prod[51:35];
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== design/lidar_yaw_time_reconstructor_core.sv =====
// Top level: sequencer, shared multiplier, ring state and output register.
// A point that yields a result passes through these steps after it is
// accepted: the squared range from x, y and z on the shared 25x25
// multiplier, the range and ring check, the CORDIC yaw, one multiply, the
// divider start, the reciprocal time division and the load of the output
// register. A dropped point returns to idle after the check, the first point
// of a ring after the yaw, a decimated-out point after the division; a point
// at the origin skips the CORDIC rotations. Input ready is high only while
// the sequencer is idle; a result waits in the output register while the next
// point is accepted, and a full output register holds the sequencer until the
// receiver takes it.
module lidar_yaw_time_reconstructor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lyt_in_if.sink      i_pt,
    lyt_out_if.source   o_pt,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_data
);

    localparam int RW = lyt_pkg::RING_W;

    lyt_pkg::t_state r_state, n_state;

    logic [39:0] r_blind;
    logic [6:0]  r_dec;
    logic [7:0]  r_rcnt;
    logic        r_ren;

    logic               r_ok, r_emit;
    logic signed [23:0] r_x, r_y, r_z;
    logic [15:0]        r_str;
    logic [7:0]         r_layer;
    logic [5:0]         r_phase;
    logic [1:0]         r_cnt;
    logic [47:0]        r_norm;
    logic [16:0]        r_d;
    logic [33:0]        r_num;
    logic [17:0]        r_t;
    logic [lyt_pkg::MAX_RINGS-1:0] r_seen;

    logic signed [16:0] mem_start [lyt_pkg::MAX_RINGS];
    logic [17:0]        mem_last  [lyt_pkg::MAX_RINGS];
    logic signed [16:0] r_start_rd;
    logic [17:0]        r_last_rd;

    logic               r_ovalid;
    logic signed [23:0] r_ox, r_oy, r_oz;
    logic [15:0]        r_ostr;
    logic [6:0]         r_oring;
    logic [17:0]        r_otime;

    logic               acc, drop, cor_start, cor_done, div_start, div_done, load;
    logic signed [16:0] yaw;
    logic [16:0]        quo;
    logic signed [24:0] mul_a, mul_b;
    logic signed [49:0] prod;
    logic [8:0]         rings;
    logic [5:0]         ph;
    logic [6:0]         dec;
    logic [RW-1:0]      ridx;
    logic [17:0]        t_raw, t_adj;

    assign ridx = r_layer[RW-1:0];
    assign acc  = i_pt.valid && i_pt.ready;
    assign i_pt.ready = (r_state == lyt_pkg::S_IDLE);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blind <= '0;
            r_dec   <= 7'd1;
            r_rcnt  <= 8'd16;
            r_ren   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lyt_pkg::CFG_BLIND:   r_blind <= i_cfg_data;
                lyt_pkg::CFG_DECIM:   r_dec   <= i_cfg_data[6:0];
                lyt_pkg::CFG_RINGS:   r_rcnt  <= i_cfg_data[7:0];
                lyt_pkg::CFG_RING_EN: r_ren   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_dec == 7'd0)       dec = 7'd1;
        else if (r_dec > 7'd64)  dec = 7'd64;
        else                     dec = r_dec;
        ph = i_pt.scan_start ? 6'd0 : r_phase;
        if (!r_ren)                                  rings = 9'd1;
        else if (r_rcnt == 8'd0)                     rings = 9'd1;
        else if (9'(r_rcnt) > 9'(lyt_pkg::MAX_RINGS)) rings = 9'(lyt_pkg::MAX_RINGS);
        else                                         rings = 9'(r_rcnt);
    end

    assign drop = !r_ok || (r_norm < 48'(r_blind)) || (9'(r_layer) >= rings);

    // shared multiplier
    always_comb begin
        mul_a = 25'(r_x);
        mul_b = 25'(r_x);
        unique case (r_state)
            lyt_pkg::S_NORM: begin
                case (r_cnt)
                    2'd0:    begin mul_a = 25'(r_x); mul_b = 25'(r_x); end
                    2'd1:    begin mul_a = 25'(r_y); mul_b = 25'(r_y); end
                    default: begin mul_a = 25'(r_z); mul_b = 25'(r_z); end
                endcase
            end
            lyt_pkg::S_MULT: begin
                mul_a = $signed({8'd0, r_d});
                mul_b = $signed({8'd0, lyt_pkg::TIME_MUL});
            end
            default: ;
        endcase
    end
    assign prod = mul_a * mul_b;

    lyt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_x     (r_x),
        .i_y     (r_y),
        .o_done  (cor_done),
        .o_yaw   (yaw)
    );

    lyt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // wrap time forward by one revolution if it would go backward, then clamp to TIME_MAX
    always_comb begin
        t_raw = 18'(quo);
        t_adj = (t_raw < r_last_rd) ? t_raw + lyt_pkg::REV_US : t_raw;
        if (t_adj > lyt_pkg::TIME_MAX)
            t_adj = lyt_pkg::TIME_MAX;
    end

    assign load = (r_state == lyt_pkg::S_OUT) && (!r_ovalid || o_pt.ready);

    always_comb begin
        n_state   = r_state;
        cor_start = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            lyt_pkg::S_IDLE:   if (acc) n_state = lyt_pkg::S_NORM;
            lyt_pkg::S_NORM:   if (r_cnt == 2'd2) n_state = lyt_pkg::S_CHECK;
            lyt_pkg::S_CHECK: begin
                if (drop) begin
                    n_state = lyt_pkg::S_IDLE;
                end else begin
                    cor_start = 1'b1;
                    n_state   = lyt_pkg::S_CORDIC;
                end
            end
            lyt_pkg::S_CORDIC:
                if (cor_done) n_state = r_seen[ridx] ? lyt_pkg::S_MULT : lyt_pkg::S_IDLE;
            lyt_pkg::S_MULT:   n_state = lyt_pkg::S_DSTART;
            lyt_pkg::S_DSTART: begin
                div_start = 1'b1;
                n_state   = lyt_pkg::S_DIV;
            end
            lyt_pkg::S_DIV:
                if (div_done) n_state = r_emit ? lyt_pkg::S_OUT : lyt_pkg::S_IDLE;
            lyt_pkg::S_OUT:    if (load) n_state = lyt_pkg::S_IDLE;
            default:           n_state = lyt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lyt_pkg::S_IDLE;
            r_phase <= '0;
            r_seen  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                if (i_pt.scan_start) r_seen <= '0;
                r_phase <= (7'(ph) + 7'd1 >= dec) ? 6'd0 : ph + 6'd1;
            end
            if (r_state == lyt_pkg::S_CORDIC && cor_done)
                r_seen[ridx] <= 1'b1;
            if (load)
                r_ovalid <= 1'b1;
            else if (o_pt.ready)
                r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ok    <= i_pt.coord_ok;
            r_x     <= i_pt.pos_x;
            r_y     <= i_pt.pos_y;
            r_z     <= i_pt.pos_z;
            r_str   <= i_pt.strength;
            r_layer <= r_ren ? i_pt.ring_id : 8'd0;
            r_emit  <= (ph == 6'd0);
            r_cnt   <= '0;
            r_norm  <= '0;
        end
        if (r_state == lyt_pkg::S_NORM) begin
            r_norm <= r_norm + prod[47:0];
            r_cnt  <= r_cnt + 2'd1;
        end
        if (r_state == lyt_pkg::S_CORDIC && cor_done)
            r_d <= (yaw <= r_start_rd) ? 17'(r_start_rd - yaw)
                                       : 17'(r_start_rd - yaw) + lyt_pkg::FULL_TURN;
        if (r_state == lyt_pkg::S_MULT)
            r_num <= prod[33:0] + lyt_pkg::TIME_BIAS;
        if (r_state == lyt_pkg::S_DIV && div_done)
            r_t <= t_adj;
        if (load) begin
            r_ox    <= r_x;
            r_oy    <= r_y;
            r_oz    <= r_z;
            r_ostr  <= r_str;
            r_oring <= r_layer[6:0];
            r_otime <= r_t;
        end
    end

    // per-ring start yaw and last time
    always_ff @(posedge i_clk) begin
        r_start_rd <= mem_start[ridx];
        r_last_rd  <= mem_last[ridx];
        if (r_state == lyt_pkg::S_CORDIC && cor_done && !r_seen[ridx]) begin
            mem_start[ridx] <= yaw;
            mem_last[ridx]  <= '0;
        end else if (r_state == lyt_pkg::S_DIV && div_done) begin
            mem_last[ridx]  <= t_adj;
        end
    end

    assign o_pt.valid        = r_ovalid;
    assign o_pt.out_x        = r_ox;
    assign o_pt.out_y        = r_oy;
    assign o_pt.out_z        = r_oz;
    assign o_pt.out_strength = r_ostr;
    assign o_pt.out_ring     = r_oring;
    assign o_pt.time_us      = r_otime;

    a_cor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_done |-> r_state == lyt_pkg::S_CORDIC)
        else $error("yaw finished outside yaw wait");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == lyt_pkg::S_DIV)
        else $error("division finished outside divide wait");
    a_scan_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_pt.scan_start) |=> r_seen == '0)
        else $error("ring state not cleared on scan start");
    a_time_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt.valid |-> o_pt.time_us <= lyt_pkg::TIME_MAX)
        else $error("time out of range");

endmodule
